@@ design/ist_pkg.sv @@
// shared types and codes for the integer set table
package ist_pkg;

	// default number of cells in the chain
	localparam int IST_CAPACITY = 64;

	// fixed field widths
	localparam int DATA_W = 32;
	localparam int CFG_W  = 7;
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;

	// request kinds
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_DUP       = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// broadcast command from the controller to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} cell_cmd_t;

	// bounds wave handed from cell to cell
	typedef struct packed {
		logic                     go;
		logic                     any;
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] lo;
	} wave_t;

endpackage

@@ design/ist_if.sv @@
// request and result channel interfaces of the integer set table
interface ist_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  operation;
	logic signed [31:0] item;

	modport source (output valid, operation, item, input ready);
	modport sink (input valid, operation, item, output ready);
endinterface

interface ist_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic               found;
	logic        [5:0]  position;
	logic        [6:0]  count;
	logic               is_empty;
	logic signed [31:0] highest;
	logic signed [31:0] lowest;

	modport source (output valid, status, found, position, count, is_empty, highest, lowest,
		input ready);
	modport sink (input valid, status, found, position, count, is_empty, highest, lowest,
		output ready);
endinterface

@@ design/integer_set_table_top.sv @@
// top level of the integer set table: controller, cell chain and result register
//
// Holds up to CAPACITY distinct signed 32-bit values in insertion order, one per cell.
// Requests come in on req (operation, item) and each gives exactly one result item on
// rsp: status, found, position, count, is_empty, highest and lowest.
// An item is taken when req.valid and req.ready are both high; req.ready is high
// only while the controller is idle.
// Each request steps through compare, decode, update, bounds scan and output; compare
// and update act in all cells at once, and the highest/lowest bounds travel as a wave
// through the cell chain, one cell per cycle.
// The result waits in the output register while rsp.ready is low; the controller
// holds the next result back until that register is free, then returns to idle.
// cfg_we/cfg_wdata write the capacity limit (reset 64, saturating at CAPACITY);
// write it only while idle.
// Asynchronous reset empties the set and clears rsp.valid; no clearing pass is needed
// because cells at or beyond the count are never read.
module integer_set_table_top #(
	parameter int CAPACITY = ist_pkg::IST_CAPACITY
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ist_pkg::CFG_W-1:0]  cfg_wdata,
	ist_req_if.sink                    req,
	ist_rsp_if.source                  rsp
);
	import ist_pkg::*;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W_L = $clog2(CAPACITY + 1);
	localparam int CNT_X_W = (CNT_W_L > CNT_W) ? CNT_W_L : CNT_W;
	localparam int POS_X_W = (IDX_W > POS_W) ? IDX_W : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_DEC,
		S_UPD,
		S_SCAN,
		S_OUT
	} state_t;

	state_t                   state_q;
	logic [1:0]               op_q;
	logic signed [DATA_W-1:0] item_q;
	logic [CNT_W_L-1:0]       count_q;
	logic [CFG_W-1:0]         limit_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         pos_q;
	logic [1:0]               status_q;
	logic                     scan_go_q;
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W-1:0] lo_q;

	logic                     rsp_valid_q;
	logic [1:0]               rsp_status_q;
	logic                     rsp_found_q;
	logic [POS_W-1:0]         rsp_pos_q;
	logic [CNT_W-1:0]         rsp_count_q;
	logic                     rsp_empty_q;
	logic signed [DATA_W-1:0] rsp_hi_q;
	logic signed [DATA_W-1:0] rsp_lo_q;

	cell_cmd_t                cmd;
	logic [CAPACITY-1:0]      match_w;
	logic signed [DATA_W-1:0] entry_w [CAPACITY];
	wave_t                    wave_w [CAPACITY+1];
	logic                     hit_d;
	logic [IDX_W-1:0]         pos_d;
	logic [CNT_X_W-1:0]       cnt_x;
	logic [CNT_X_W-1:0]       lim_cfg;
	logic [CNT_X_W-1:0]       lim_cap;
	logic [CNT_X_W-1:0]       limit;
	logic                     full;
	logic [1:0]               status_d;
	logic                     do_ins;
	logic                     do_rem;
	logic [POS_X_W-1:0]       pos_x;
	logic                     out_free;

	// match reduction: entries are distinct, so at most one cell hits
	always_comb begin
		hit_d = |match_w;
		pos_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_w[i]) begin
				pos_d = pos_d | IDX_W'(i);
			end
		end
	end

	// limit in force and full check
	assign cnt_x   = CNT_X_W'(count_q);
	assign lim_cfg = CNT_X_W'(limit_q);
	assign lim_cap = CNT_X_W'(CAPACITY);
	assign limit   = (lim_cfg < lim_cap) ? lim_cfg : lim_cap;
	assign full    = cnt_x >= limit;

	// request decision once the match is known
	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		status_d = ST_DONE;
		case (op_q)
			OP_INSERT: begin
				if (hit_q) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					do_rem = 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				status_d = hit_q ? ST_DONE : ST_NOT_FOUND;
			end
		endcase
	end

	// command broadcast to the cells
	always_comb begin
		cmd.cmp = (state_q == S_CMP);
		cmd.ins = (state_q == S_UPD) && do_ins;
		cmd.rem = (state_q == S_UPD) && do_rem;
	end

	assign out_free = !rsp_valid_q || rsp.ready;
	assign pos_x    = POS_X_W'(pos_q);

	// controller and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_SEARCH;
			item_q       <= '0;
			count_q      <= '0;
			limit_q      <= CFG_W'(64);
			hit_q        <= 1'b0;
			pos_q        <= '0;
			status_q     <= ST_DONE;
			scan_go_q    <= 1'b0;
			hi_q         <= '0;
			lo_q         <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_found_q  <= 1'b0;
			rsp_pos_q    <= '0;
			rsp_count_q  <= '0;
			rsp_empty_q  <= 1'b1;
			rsp_hi_q     <= '0;
			rsp_lo_q     <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// result register fill and drain
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			// launch the bounds wave right after the update
			scan_go_q <= (state_q == S_UPD);
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.operation;
						item_q  <= req.item;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					hit_q   <= hit_d;
					pos_q   <= pos_d;
					state_q <= S_UPD;
				end
				S_UPD: begin
					status_q <= status_d;
					if (do_ins) begin
						count_q <= count_q + CNT_W_L'(1);
					end else if (do_rem) begin
						count_q <= count_q - CNT_W_L'(1);
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (wave_w[CAPACITY].go) begin
						hi_q    <= wave_w[CAPACITY].hi;
						lo_q    <= wave_w[CAPACITY].lo;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_status_q <= status_q;
						rsp_found_q  <= hit_q;
						rsp_pos_q    <= pos_x[POS_W-1:0];
						rsp_count_q  <= cnt_x[CNT_W-1:0];
						rsp_empty_q  <= (count_q == '0);
						rsp_hi_q     <= hi_q;
						rsp_lo_q     <= lo_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// seed of the bounds wave, empty set reads as zero
	assign wave_w[0] = '{go: scan_go_q, any: 1'b0, hi: '0, lo: '0};

	// the cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] right_w;
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = entry_w[g];
		end else begin : g_mid
			assign right_w = entry_w[g+1];
		end
		ist_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.item        (item_q),
			.count       (count_q),
			.pos         (pos_q),
			.right_entry (right_w),
			.entry       (entry_w[g]),
			.match       (match_w[g]),
			.wave_in     (wave_w[g]),
			.wave_out    (wave_w[g+1])
		);
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.position = rsp_pos_q;
	assign rsp.count    = rsp_count_q;
	assign rsp.is_empty = rsp_empty_q;
	assign rsp.highest  = rsp_hi_q;
	assign rsp.lowest   = rsp_lo_q;

`ifndef SYNTHESIS
	// stored values are distinct, so a compare hits at most one cell
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC) |-> $onehot0(match_w))
		else $error("more than one cell matched the request");

	// the set never grows past the cell count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W_L'(CAPACITY))
		else $error("entry count beyond capacity");

	// a hit remove drops the count by one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && op_q == OP_REMOVE && hit_q)
		|=> count_q == $past(count_q) - CNT_W_L'(1))
		else $error("remove did not shrink the set");

	// the bounds wave only leaves the chain during a scan
	a_wave_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wave_w[CAPACITY].go |-> state_q == S_SCAN)
		else $error("bounds wave outside a scan");
`endif

endmodule

@@ design/ist_cell.sv @@
// one storage cell of the set chain: entry, compare, shift and bounds wave
module ist_cell #(
	parameter int CAPACITY = ist_pkg::IST_CAPACITY,
	parameter int IDX      = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ist_pkg::cell_cmd_t                cmd,
	input  logic signed [ist_pkg::DATA_W-1:0] item,
	input  logic [$clog2(CAPACITY+1)-1:0]     count,
	input  logic [$clog2(CAPACITY)-1:0]       pos,
	input  logic signed [ist_pkg::DATA_W-1:0] right_entry,
	output logic signed [ist_pkg::DATA_W-1:0] entry,
	output logic                              match,
	input  ist_pkg::wave_t                    wave_in,
	output ist_pkg::wave_t                    wave_out
);
	import ist_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W_L = $clog2(CAPACITY + 1);

	logic signed [DATA_W-1:0] entry_q;
	logic                     match_q;
	wave_t                    wave_q;
	wave_t                    wave_d;
	logic                     occ;

	// this cell holds a live entry
	assign occ = CNT_W_L'(IDX) < count;

	// entry store: append at the tail, shift down past a removed entry
	always_ff @(posedge clk) begin
		if (cmd.ins && (CNT_W_L'(IDX) == count)) begin
			entry_q <= item;
		end else if (cmd.rem && (IDX_W'(IDX) >= pos)) begin
			entry_q <= right_entry;
		end
	end

	// compare against the request value
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			match_q <= occ && (entry_q == item);
		end
	end

	// fold this entry into the passing bounds wave
	always_comb begin
		wave_d = wave_in;
		if (wave_in.go && occ) begin
			if (!wave_in.any) begin
				wave_d.any = 1'b1;
				wave_d.hi  = entry_q;
				wave_d.lo  = entry_q;
			end else begin
				if (entry_q > wave_in.hi) begin
					wave_d.hi = entry_q;
				end
				if (entry_q < wave_in.lo) begin
					wave_d.lo = entry_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_d;
		end
	end

	assign entry    = entry_q;
	assign match    = match_q;
	assign wave_out = wave_q;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the integer set table: directed rows, then random phases
`timescale 1ns / 1ps

module testbench;
	import ist_pkg::*;

	localparam int CAP          = IST_CAPACITY;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = CAP + 10;
	localparam int REPORT_LIMIT = 10;

	// the spare operation code behaves as a search
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [5:0]         position;
		logic [6:0]         count;
		logic               is_empty;
		logic signed [31:0] highest;
		logic signed [31:0] lowest;
	} set_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [1:0]         op;
		logic signed [31:0] value;
		logic               typed;
		set_result_t        want;
	} stim_row_t;

	localparam set_result_t NO_WANT = '0;

	// directed rows; typed results only where they are obvious
	localparam stim_row_t DIRECTED [26] = '{
		'{ROW_REQ, OP_SEARCH, 32'sd0, 1'b1,
			'{ST_NOT_FOUND, 1'b0, 6'd0, 7'd0, 1'b1, 32'sd0, 32'sd0}},
		'{ROW_REQ, OP_REMOVE, 32'sd5, 1'b1,
			'{ST_NOT_FOUND, 1'b0, 6'd0, 7'd0, 1'b1, 32'sd0, 32'sd0}},
		'{ROW_REQ, OP_INSERT, MAXV, 1'b1,
			'{ST_DONE, 1'b0, 6'd0, 7'd1, 1'b0, MAXV, MAXV}},
		'{ROW_REQ, OP_INSERT, MINV, 1'b1,
			'{ST_DONE, 1'b0, 6'd0, 7'd2, 1'b0, MAXV, MINV}},
		'{ROW_REQ, OP_INSERT, MAXV, 1'b1,
			'{ST_DUP, 1'b1, 6'd0, 7'd2, 1'b0, MAXV, MINV}},
		'{ROW_REQ, OP_INSERT, 32'sd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_INSERT, -32'sd1, 1'b0, NO_WANT},
		'{ROW_REQ, OP_SEARCH, MINV, 1'b1,
			'{ST_DONE, 1'b1, 6'd1, 7'd4, 1'b0, MAXV, MINV}},
		'{ROW_REQ, OP_SPARE, -32'sd1, 1'b0, NO_WANT},
		'{ROW_REQ, OP_SPARE, 32'sd12345, 1'b0, NO_WANT},
		'{ROW_REQ, OP_REMOVE, MINV, 1'b0, NO_WANT},
		'{ROW_REQ, OP_SEARCH, -32'sd1, 1'b0, NO_WANT},
		'{ROW_REQ, OP_REMOVE, MAXV, 1'b0, NO_WANT},
		'{ROW_REQ, OP_INSERT, 32'sh5555_5555, 1'b0, NO_WANT},
		'{ROW_REQ, OP_INSERT, 32'shAAAA_AAAA, 1'b0, NO_WANT},
		'{ROW_REQ, OP_REMOVE, 32'sd7, 1'b0, NO_WANT},
		'{ROW_CFG, OP_INSERT, 32'sd0, 1'b0, NO_WANT},
		'{ROW_REQ, OP_INSERT, 32'sd99, 1'b0, NO_WANT},
		'{ROW_REQ, OP_REMOVE, -32'sd1, 1'b0, NO_WANT},
		'{ROW_CFG, OP_INSERT, 32'sd2, 1'b0, NO_WANT},
		'{ROW_REQ, OP_INSERT, 32'sd42, 1'b0, NO_WANT},
		'{ROW_REQ, OP_SEARCH, 32'sd0, 1'b0, NO_WANT},
		'{ROW_CFG, OP_INSERT, 32'sd127, 1'b0, NO_WANT},
		'{ROW_REQ, OP_INSERT, 32'sd42, 1'b0, NO_WANT},
		'{ROW_REQ, OP_REMOVE, 32'shAAAA_AAAA, 1'b0, NO_WANT},
		'{ROW_CFG, OP_INSERT, 32'sd64, 1'b0, NO_WANT}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;

	ist_req_if req_ch ();
	ist_rsp_if rsp_ch ();

	integer_set_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// model of the set contents and limit
	logic signed [31:0] set_cells [CAP];
	int                 set_fill;
	int                 peak_fill;
	logic [6:0]         limit_reg;

	set_result_t        expected_q [$];

	int mismatches;
	int results_seen;
	int requests_sent;
	int status_seen [4];
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_asks;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	// apply one request to the model and return its result
	function automatic set_result_t apply_request(input logic [1:0] op,
			input logic signed [31:0] value);
		set_result_t        r;
		int                 hit_at;
		int                 lim;
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		hit_at = -1;
		for (int i = 0; i < set_fill; i++) begin
			if (hit_at < 0 && set_cells[i] === value)
				hit_at = i;
		end
		lim = (int'(limit_reg) < CAP) ? int'(limit_reg) : CAP;
		r = '0;
		r.found = (hit_at >= 0);
		r.position = r.found ? 6'(hit_at) : 6'd0;
		case (op)
			OP_INSERT: begin
				if (r.found) begin
					r.status = ST_DUP;
				end else if (set_fill >= lim) begin
					r.status = ST_FULL;
				end else begin
					set_cells[set_fill] = value;
					set_fill++;
					r.status = ST_DONE;
				end
			end
			OP_REMOVE: begin
				if (!r.found) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// close the gap
					for (int i = hit_at; i < set_fill - 1; i++)
						set_cells[i] = set_cells[i + 1];
					set_fill--;
					r.status = ST_DONE;
				end
			end
			default: begin
				r.status = r.found ? ST_DONE : ST_NOT_FOUND;
			end
		endcase
		hi = '0;
		lo = '0;
		if (set_fill > 0) begin
			hi = set_cells[0];
			lo = hi;
			for (int i = 1; i < set_fill; i++) begin
				if (set_cells[i] > hi)
					hi = set_cells[i];
				if (set_cells[i] < lo)
					lo = set_cells[i];
			end
		end
		r.count = 7'(set_fill);
		r.is_empty = (set_fill == 0);
		r.highest = hi;
		r.lowest = lo;
		if (set_fill > peak_fill)
			peak_fill = set_fill;
		return r;
	endfunction

	// value mix: members, a small pool, extremes and raw random words
	function automatic logic signed [31:0] pick_value();
		int                 r;
		logic signed [31:0] v;
		r = $urandom_range(99);
		if (r < 40 && set_fill > 0) begin
			v = set_cells[$urandom_range(set_fill - 1)];
		end else if (r < 70) begin
			v = int'($urandom_range(24)) - 12;
		end else if (r < 80) begin
			case ($urandom_range(3))
				0:       v = MAXV;
				1:       v = MINV;
				2:       v = MAXV - 1;
				default: v = MINV + 1;
			endcase
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	// present one item, queue its result once it is taken
	task automatic offer(input logic [1:0] op, input logic signed [31:0] value,
			input set_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.item      <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_q.push_back(want);
		requests_sent++;
	endtask

	// stop offering until all results are back and the block is idle
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0 || !req_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [6:0] limit);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_reg = limit;
	endtask

	// one random phase at a given limit and idle mix
	task automatic run_phase(input int n, input logic [6:0] limit, input int ins_pct,
			input int rem_pct, input int send_pct, input int recv_pct,
			input bit with_hold, input bit with_pause);
		int                 r;
		logic [1:0]         op;
		logic signed [31:0] value;
		set_result_t        want;
		write_limit(limit);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		for (int k = 0; k < n; k++) begin
			if (with_hold && k == n / 3)
				hold_asks <= hold_asks + 1;
			if (with_pause && k == n / 2)
				wait_idle();
			r = $urandom_range(99);
			if (r < 3)
				op = OP_SPARE;
			else if (r < 3 + ins_pct)
				op = OP_INSERT;
			else if (r < 3 + ins_pct + rem_pct)
				op = OP_REMOVE;
			else
				op = OP_SEARCH;
			value = pick_value();
			want = apply_request(op, value);
			offer(op, value, want);
		end
	endtask

	// result side: random stalls, long hold-off on request, compare with queue
	initial begin
		set_result_t got;
		set_result_t want;
		logic        bad;
		int          hold_served;
		int          hold_left;
		hold_served = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status   = rsp_ch.status;
				got.found    = rsp_ch.found;
				got.position = rsp_ch.position;
				got.count    = rsp_ch.count;
				got.is_empty = rsp_ch.is_empty;
				got.highest  = rsp_ch.highest;
				got.lowest   = rsp_ch.lowest;
				results_seen++;
				status_seen[got.status]++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result item with nothing expected: st=%0d cnt=%0d",
							$time, got.status, got.count);
				end else begin
					want = expected_q.pop_front();
					bad = (got.status !== want.status) || (got.found !== want.found) ||
						(got.position !== want.position) || (got.count !== want.count) ||
						(got.is_empty !== want.is_empty) ||
						(got.highest !== want.highest) || (got.lowest !== want.lowest);
					if (bad) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: result %0d exp st=%0d f=%0d pos=%0d cnt=%0d e=%0d hi=%0d lo=%0d",
								$time, results_seen, want.status, want.found, want.position,
								want.count, want.is_empty, want.highest, want.lowest);
							$display("%0t: result %0d got st=%0d f=%0d pos=%0d cnt=%0d e=%0d hi=%0d lo=%0d",
								$time, results_seen, got.status, got.found, got.position,
								got.count, got.is_empty, got.highest, got.lowest);
						end
					end
				end
			end
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// stimulus
	initial begin
		set_result_t want;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_INSERT;
		req_ch.item      = '0;
		set_fill         = 0;
		peak_fill        = 0;
		limit_reg        = 7'd64;
		mismatches       = 0;
		results_seen     = 0;
		requests_sent    = 0;
		cycle_count      = 0;
		hold_asks        = 0;
		send_idle_pct    = 25;
		recv_idle_pct    = 67;
		foreach (status_seen[i])
			status_seen[i] = 0;
		foreach (set_cells[i])
			set_cells[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_limit(DIRECTED[i].value[6:0]);
			end else begin
				want = apply_request(DIRECTED[i].op, DIRECTED[i].value);
				if (DIRECTED[i].typed)
					want = DIRECTED[i].want;
				offer(DIRECTED[i].op, DIRECTED[i].value, want);
			end
		end

		// random phases across limits and idle mixes
		run_phase(300, 7'd64, 65, 15, 25, 67, 1'b1, 1'b0);
		run_phase(280, 7'd1, 40, 30, 25, 67, 1'b0, 1'b0);
		run_phase(300, 7'd127, 60, 20, 67, 25, 1'b0, 1'b1);
		run_phase(280, 7'd0, 25, 40, 67, 25, 1'b0, 1'b0);
		run_phase(290, 7'($urandom_range(63, 2)), 45, 30, 0, 0, 1'b0, 1'b0);
		run_phase(280, 7'd64, 50, 25, 0, 0, 1'b0, 1'b0);

		// drain, then watch for stray result items
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d result items in %0d cycles, peak occupancy %0d",
			requests_sent, results_seen, cycle_count, peak_fill);
		$display("statuses done %0d, duplicate %0d, not found %0d, full %0d; mismatches %0d",
			status_seen[ST_DONE], status_seen[ST_DUP], status_seen[ST_NOT_FOUND],
			status_seen[ST_FULL], mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
